/* rtl/lcd3w_pkg.sv */
// Shared types and constants for the three-wire display bus serializer.
package lcd3w_pkg;

    // Widths fixed by the item fields
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned VALUE_W     = 8;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned FRAME_MAX   = 12;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Item mode codes
    localparam logic [MODE_W-1:0] MODE_CMD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEADER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DATA   = 2'd2;

    // Frame prefixes, sent first bit leftmost
    localparam logic [2:0] PREFIX_CMD   = 3'b100;
    localparam logic [2:0] PREFIX_WRITE = 3'b101;

    // Frame lengths in bits
    localparam logic [LEN_W-1:0] LEN_CMD    = 4'd12;
    localparam logic [LEN_W-1:0] LEN_HEADER = 4'd11;
    localparam logic [LEN_W-1:0] LEN_ERROR  = 4'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd8;

    // One serial job: bits[FRAME_MAX-1] leaves first
    typedef struct packed {
        logic [FRAME_MAX-1:0] bits;
        logic [LEN_W-1:0]     len;
        logic                 opens;
        logic                 ends;
        logic                 err;
    } job_t;

endpackage

/* rtl/lcd3w_front.sv */
// Front end: checks item order, tracks the open write frame, builds serial jobs.
module lcd3w_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [lcd3w_pkg::MODE_W-1:0]        mode,
    input  logic [lcd3w_pkg::VALUE_W-1:0]       value,
    input  logic [lcd3w_pkg::COUNT_W-1:0]       bit_count,
    input  logic                                end_of_write,
    output lcd3w_pkg::job_t                     job
);

    logic                               frame_open_reg;
    logic                               frame_open_next;
    logic [lcd3w_pkg::COUNT_W-1:0]      count_sat;
    logic [lcd3w_pkg::FRAME_MAX-1:0]    data_bits;

    // Saturate the data bit count and reverse the byte so LSB leaves first
    always_comb
    begin
        count_sat = (bit_count > lcd3w_pkg::COUNT_MAX) ? lcd3w_pkg::COUNT_MAX : bit_count;
        data_bits = '0;
        for (int i = 0; i < lcd3w_pkg::BYTE_BITS; i++)
        begin
            data_bits[lcd3w_pkg::FRAME_MAX-1-i] = value[i];
        end
    end

    // Classify the transaction and form the job
    always_comb
    begin
        job             = '0;
        job.len         = lcd3w_pkg::LEN_ERROR;
        job.err         = 1'b1;
        frame_open_next = frame_open_reg;
        unique case (mode)
            lcd3w_pkg::MODE_CMD:
            begin
                if (!frame_open_reg)
                begin
                    job.bits  = {lcd3w_pkg::PREFIX_CMD, value, 1'b0};
                    job.len   = lcd3w_pkg::LEN_CMD;
                    job.opens = 1'b1;
                    job.ends  = 1'b1;
                    job.err   = 1'b0;
                end
            end
            lcd3w_pkg::MODE_HEADER:
            begin
                if (!frame_open_reg)
                begin
                    job.bits        = {lcd3w_pkg::PREFIX_WRITE, value, 1'b0};
                    job.len         = lcd3w_pkg::LEN_HEADER;
                    job.opens       = 1'b1;
                    job.ends        = end_of_write;
                    job.err         = 1'b0;
                    frame_open_next = !end_of_write;
                end
            end
            lcd3w_pkg::MODE_DATA:
            begin
                if (frame_open_reg && (bit_count != '0))
                begin
                    job.bits = data_bits;
                    job.len  = count_sat;
                    job.ends = end_of_write;
                    job.err  = 1'b0;
                    if (end_of_write)
                    begin
                        frame_open_next = 1'b0;
                    end
                end
            end
            default:
            begin
                job.err = 1'b1;
            end
        endcase
    end

    // Advance the frame state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

/* rtl/lcd3w_queue.sv */
// Job queue between the front end and the serializer.
module lcd3w_queue
#(
    parameter int unsigned DEPTH = lcd3w_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  lcd3w_pkg::job_t wr_job,
    output logic            full,
    input  logic            rd_en,
    output lcd3w_pkg::job_t rd_job,
    output logic            rd_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lcd3w_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign full     = (cnt_reg == CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the job
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

/* rtl/lcd3w_back.sv */
// Back end: shifts jobs out one bit per result into the output register.
module lcd3w_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  lcd3w_pkg::job_t q_job,
    input  logic            q_valid,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic            wire_bit,
    output logic            frame_start,
    output logic            frame_end,
    output logic            sequence_error,
    output logic            last
);

    logic [lcd3w_pkg::FRAME_MAX-1:0] shift_reg;
    logic [lcd3w_pkg::FRAME_MAX-1:0] shift_next;
    logic [lcd3w_pkg::LEN_W-1:0]     remain_reg;
    logic [lcd3w_pkg::LEN_W-1:0]     remain_next;
    logic                            opens_reg;
    logic                            opens_next;
    logic                            ends_reg;
    logic                            ends_next;
    logic                            err_reg;
    logic                            err_next;
    logic                            job_valid_reg;
    logic                            job_valid_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            bit_reg;
    logic                            bit_next;
    logic                            start_reg;
    logic                            start_next;
    logic                            end_reg;
    logic                            end_next;
    logic                            error_reg;
    logic                            error_next;
    logic                            last_reg;
    logic                            last_next;
    logic                            out_load;
    logic                            emit;
    logic                            emit_last;

    assign out_load  = !out_valid_reg || pop;
    assign emit      = job_valid_reg && out_load;
    assign emit_last = emit && (remain_reg == lcd3w_pkg::LEN_W'(1));
    assign q_pop     = q_valid && (!job_valid_reg || emit_last);

    // Emit the next bit and step the current job; take a new job when done
    always_comb
    begin
        shift_next     = shift_reg;
        remain_next    = remain_reg;
        opens_next     = opens_reg;
        ends_next      = ends_reg;
        err_next       = err_reg;
        job_valid_next = job_valid_reg;
        out_valid_next = out_valid_reg;
        bit_next       = bit_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        error_next     = error_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            bit_next       = shift_reg[lcd3w_pkg::FRAME_MAX-1];
            start_next     = opens_reg;
            last_next      = emit_last;
            end_next       = ends_reg && emit_last;
            error_next     = err_reg;
            shift_next     = {shift_reg[lcd3w_pkg::FRAME_MAX-2:0], 1'b0};
            remain_next    = remain_reg - 1'b1;
            opens_next     = 1'b0;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (!job_valid_reg || emit_last)
        begin
            job_valid_next = q_valid;
            shift_next     = q_job.bits;
            remain_next    = q_job.len;
            opens_next     = q_job.opens;
            ends_next      = q_job.ends;
            err_next       = q_job.err;
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        remain_reg <= remain_next;
        opens_reg  <= opens_next;
        ends_reg   <= ends_next;
        err_reg    <= err_next;
        bit_reg    <= bit_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        error_reg  <= error_next;
        last_reg   <= last_next;
    end

    assign empty          = !out_valid_reg;
    assign wire_bit       = bit_reg;
    assign frame_start    = start_reg;
    assign frame_end      = end_reg;
    assign sequence_error = error_reg;
    assign last           = last_reg;

endmodule

/* rtl/lcd_three_wire_frame_serializer.sv */
// Top level of the three-wire display bus serializer.
//
//  Channel   Handshake          Payload
//  input     push / full        mode, value, bit_count, end_of_write
//  result    empty / pop        wire_bit, frame_start, frame_end, sequence_error, last
//
// One result bit leaves the serializer per cycle while the receiver pops and jobs are queued;
// an item has 12 bits for a command, 11 for a header, 1 to 8 for data, 1 for an error.
// While not full, the front end takes one transaction per cycle into a QUEUE_DEPTH job queue, so
// items are accepted while earlier frames are still shifting out.
// Reset clears the open-frame flag, the queue and the output valid flag.
// A stalled pop holds the result register and backs up into the queue and then full.
module lcd_three_wire_frame_serializer
#(
    parameter int unsigned QUEUE_DEPTH = lcd3w_pkg::QUEUE_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [lcd3w_pkg::MODE_W-1:0]     mode,
    input  logic [lcd3w_pkg::VALUE_W-1:0]    value,
    input  logic [lcd3w_pkg::COUNT_W-1:0]    bit_count,
    input  logic                             end_of_write,
    output logic                             empty,
    input  logic                             pop,
    output logic                             wire_bit,
    output logic                             frame_start,
    output logic                             frame_end,
    output logic                             sequence_error,
    output logic                             last
);

    lcd3w_pkg::job_t front_job;
    lcd3w_pkg::job_t q_job;
    logic            accept;
    logic            q_valid;
    logic            q_pop;

    assign accept = push && !full;

    lcd3w_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode),
        .value        (value),
        .bit_count    (bit_count),
        .end_of_write (end_of_write),
        .job          (front_job)
    );

    lcd3w_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_job   (front_job),
        .full     (full),
        .rd_en    (q_pop),
        .rd_job   (q_job),
        .rd_valid (q_valid)
    );

    lcd3w_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_job          (q_job),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .wire_bit       (wire_bit),
        .frame_start    (frame_start),
        .frame_end      (frame_end),
        .sequence_error (sequence_error),
        .last           (last)
    );

endmodule

/* dv/lcd_three_wire_frame_serializer_tb.sv */
// Self-checking testbench for the three-wire display bus frame serializer.
module lcd_three_wire_frame_serializer_tb;

    import lcd3w_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS   = 21;
    localparam int RANDOM_ITEMS    = 360;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AT_ITEM    = 80;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int PRINT_CAP       = 100;

    // One serial strobe as seen on the result ports
    typedef struct packed {
        logic wire_bit;
        logic frame_start;
        logic frame_end;
        logic sequence_error;
        logic last;
    } strobe_t;

    localparam strobe_t STROBE_ERROR = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam strobe_t STROBE_NONE  = '0;

    // One input transaction; typed rows carry their single expected strobe
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               eow;
        logic               typed;
        strobe_t            want;
    } item_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [MODE_W-1:0]    mode;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   bit_count;
    logic                 end_of_write;
    logic                 empty;
    logic                 pop;
    logic                 wire_bit;
    logic                 frame_start;
    logic                 frame_end;
    logic                 sequence_error;
    logic                 last;

    strobe_t expected_strobes [$];
    item_t   pending_items [$];
    item_t   directed_rows [DIRECTED_ROWS];
    bit      write_open = 1'b0;
    int      mismatches = 0;
    int      accepted_items = 0;

    lcd_three_wire_frame_serializer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .mode           (mode),
        .value          (value),
        .bit_count      (bit_count),
        .end_of_write   (end_of_write),
        .empty          (empty),
        .pop            (pop),
        .wire_bit       (wire_bit),
        .frame_start    (frame_start),
        .frame_end      (frame_end),
        .sequence_error (sequence_error),
        .last           (last)
    );

    always #6 clk = ~clk;

    // Count a mismatch and print one line for it, up to a cap
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Work out the strobes one accepted item causes and queue them
    task automatic serialize_item(input item_t item);
        logic [FRAME_MAX-1:0] seq;
        int  n;
        int  span;
        int  i;
        bit  opens;
        bit  ends;
        bit  reject;
        seq    = '0;
        n      = 0;
        opens  = 1'b0;
        ends   = 1'b0;
        reject = 1'b0;
        case (item.mode)
            MODE_CMD:
            begin
                if (write_open)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    seq[0] = PREFIX_CMD[2];
                    seq[1] = PREFIX_CMD[1];
                    seq[2] = PREFIX_CMD[0];
                    for (i = 0; i < BYTE_BITS; i++)
                        seq[3 + i] = item.value[BYTE_BITS - 1 - i];
                    seq[11] = 1'b0;
                    n       = 12;
                    opens   = 1'b1;
                    ends    = 1'b1;
                end
            end
            MODE_HEADER:
            begin
                if (write_open)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    seq[0] = PREFIX_WRITE[2];
                    seq[1] = PREFIX_WRITE[1];
                    seq[2] = PREFIX_WRITE[0];
                    for (i = 0; i < BYTE_BITS; i++)
                        seq[3 + i] = item.value[BYTE_BITS - 1 - i];
                    n          = 11;
                    opens      = 1'b1;
                    ends       = item.eow;
                    write_open = !item.eow;
                end
            end
            MODE_DATA:
            begin
                if (!write_open || item.count == 0)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    // Saturate oversized counts to a whole byte
                    span = (item.count > BYTE_BITS) ? BYTE_BITS : int'(item.count);
                    for (i = 0; i < span; i++)
                        seq[i] = item.value[i];
                    n    = span;
                    ends = item.eow;
                    if (item.eow)
                        write_open = 1'b0;
                end
            end
            default:
            begin
                reject = 1'b1;
            end
        endcase
        if (reject)
        begin
            expected_strobes.push_back(STROBE_ERROR);
        end
        else
        begin
            for (i = 0; i < n; i++)
                expected_strobes.push_back('{seq[i], opens && i == 0,
                                             ends && i == n - 1, 1'b0, i == n - 1});
        end
    endtask

    // Queue random items: mostly well-formed frames, some noise
    task automatic build_random_items(input int target);
        item_t item;
        int    made;
        int    pick;
        int    chunks;
        int    k;
        made = 0;
        while (made < target)
        begin
            pick = $urandom_range(0, 99);
            item = '0;
            if (pick < 12)
            begin
                item.mode  = MODE_W'($urandom_range(0, 3));
                item.value = VALUE_W'($urandom_range(0, 255));
                item.count = COUNT_W'($urandom_range(0, 15));
                item.eow   = 1'($urandom_range(0, 1));
                pending_items.push_back(item);
                made++;
            end
            else if (pick < 40)
            begin
                item.mode  = MODE_CMD;
                item.value = VALUE_W'($urandom_range(0, 255));
                item.count = COUNT_W'($urandom_range(0, 15));
                item.eow   = 1'($urandom_range(0, 1));
                pending_items.push_back(item);
                made++;
            end
            else
            begin
                item.mode  = MODE_HEADER;
                item.value = VALUE_W'($urandom_range(0, 255));
                item.count = COUNT_W'($urandom_range(0, 15));
                item.eow   = ($urandom_range(0, 9) == 0);
                pending_items.push_back(item);
                made++;
                chunks = item.eow ? 0 : $urandom_range(1, 6);
                for (k = 0; k < chunks; k++)
                begin
                    item.mode  = MODE_DATA;
                    item.value = VALUE_W'($urandom_range(0, 255));
                    item.count = ($urandom_range(0, 7) == 0) ?
                                 COUNT_W'($urandom_range(9, 15)) :
                                 COUNT_W'($urandom_range(1, 8));
                    item.eow   = (k == chunks - 1);
                    pending_items.push_back(item);
                    made++;
                end
            end
        end
    endtask

    // Reset, then offer items in bursts and predict each accepted transaction
    initial
    begin : sender
        int burst_left;
        int gap;
        int r;
        item_t head;
        rst_n        <= 1'b0;
        push         <= 1'b0;
        mode         <= MODE_CMD;
        value        <= '0;
        bit_count    <= '0;
        end_of_write <= 1'b0;
        directed_rows = '{
            '{MODE_DATA,   8'h3C, 4'd4,  1'b0, 1'b1, STROBE_ERROR}, // data with no frame
            '{MODE_UNUSED, 8'h00, 4'd0,  1'b0, 1'b1, STROBE_ERROR}, // unused mode
            '{MODE_CMD,    8'h00, 4'd0,  1'b0, 1'b0, STROBE_NONE},
            '{MODE_CMD,    8'hFF, 4'd15, 1'b0, 1'b0, STROBE_NONE},
            '{MODE_CMD,    8'hA5, 4'd8,  1'b1, 1'b0, STROBE_NONE},  // close flag ignored
            '{MODE_HEADER, 8'h00, 4'd0,  1'b0, 1'b0, STROBE_NONE},
            '{MODE_CMD,    8'h12, 4'd0,  1'b0, 1'b1, STROBE_ERROR}, // command in frame
            '{MODE_HEADER, 8'h34, 4'd0,  1'b0, 1'b1, STROBE_ERROR}, // header in frame
            '{MODE_DATA,   8'hFF, 4'd0,  1'b0, 1'b1, STROBE_ERROR}, // zero bit count
            '{MODE_DATA,   8'hFF, 4'd1,  1'b0, 1'b0, STROBE_NONE},
            '{MODE_DATA,   8'hA5, 4'd8,  1'b0, 1'b0, STROBE_NONE},
            '{MODE_DATA,   8'h5A, 4'd15, 1'b0, 1'b0, STROBE_NONE},  // saturates
            '{MODE_DATA,   8'hFF, 4'd9,  1'b1, 1'b0, STROBE_NONE},
            '{MODE_DATA,   8'h81, 4'd3,  1'b0, 1'b1, STROBE_ERROR}, // frame now closed
            '{MODE_HEADER, 8'hFF, 4'd15, 1'b1, 1'b0, STROBE_NONE},  // header closes frame
            '{MODE_DATA,   8'h00, 4'd8,  1'b0, 1'b1, STROBE_ERROR},
            '{MODE_UNUSED, 8'hFF, 4'd15, 1'b1, 1'b1, STROBE_ERROR},
            '{MODE_HEADER, 8'h3C, 4'd7,  1'b0, 1'b0, STROBE_NONE},
            '{MODE_UNUSED, 8'h5A, 4'd2,  1'b0, 1'b1, STROBE_ERROR}, // unused mode in frame
            '{MODE_DATA,   8'hC3, 4'd0,  1'b1, 1'b1, STROBE_ERROR}, // zero count keeps frame
            '{MODE_DATA,   8'h00, 4'd8,  1'b1, 1'b0, STROBE_NONE}
        };
        for (r = 0; r < DIRECTED_ROWS; r++)
            pending_items.push_back(directed_rows[r]);
        build_random_items(RANDOM_ITEMS);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        while (pending_items.size() > 0)
        begin
            // Open a gap between bursts, sometimes none
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            head = pending_items[0];
            push         <= 1'b1;
            mode         <= head.mode;
            value        <= head.value;
            bit_count    <= head.count;
            end_of_write <= head.eow;
            // Hold the item until the block takes it
            do
                @(posedge clk);
            while (full);
            if (head.typed)
                expected_strobes.push_back(head.want);
            else
                serialize_item(head);
            void'(pending_items.pop_front());
            accepted_items++;
            burst_left--;
        end
        push <= 1'b0;

        // Drain outstanding strobes, then allow for stragglers
        wait (expected_strobes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_strobes.size() != 0)
            report_mismatch($sformatf("%0d strobes never arrived", expected_strobes.size()));
        if (mismatches == 0)
        begin
            $display("lcd_three_wire_frame_serializer_tb: done, clean");
        end
        else
        begin
            $display("lcd_three_wire_frame_serializer_tb: done, errors");
        end
        $finish;
    end

    // Pop on a pattern of phases, with one long hold-off to back the block up
    initial
    begin : receiver
        int  phase_left;
        int  style;
        bit  held;
        phase_left = 0;
        style      = 0;
        held       = 1'b0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && accepted_items >= HOLD_AT_ITEM)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (phase_left == 0)
            begin
                style      = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            case (style)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each popped strobe with the oldest expectation
    always @(posedge clk)
    begin : strobe_check
        strobe_t got;
        strobe_t want;
        if (rst_n && pop && !empty)
        begin
            got = '{wire_bit, frame_start, frame_end, sequence_error, last};
            if (expected_strobes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected strobe %b", got));
            end
            else
            begin
                want = expected_strobes.pop_front();
                if (got.wire_bit !== want.wire_bit)
                    report_mismatch($sformatf("wire_bit %b, want %b",
                                              got.wire_bit, want.wire_bit));
                if (got.frame_start !== want.frame_start)
                    report_mismatch($sformatf("frame_start %b, want %b",
                                              got.frame_start, want.frame_start));
                if (got.frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              got.frame_end, want.frame_end));
                if (got.sequence_error !== want.sequence_error)
                    report_mismatch($sformatf("sequence_error %b, want %b",
                                              got.sequence_error, want.sequence_error));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
        end
    end

    // End the run when no transaction moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("lcd_three_wire_frame_serializer_tb: done, errors");
        $finish;
    end

endmodule

/* lcd_three_wire_frame_serializer.f */
rtl/lcd3w_pkg.sv
rtl/lcd3w_front.sv
rtl/lcd3w_queue.sv
rtl/lcd3w_back.sv
rtl/lcd_three_wire_frame_serializer.sv
dv/lcd_three_wire_frame_serializer_tb.sv
